@@ rtl/lpht_pkg.sv @@
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear probe hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam logic [31:0] GOLDEN_MULT = 32'h9E3779B1;

	// slot count, a power of two that matches the slot_index width
	localparam int TABLE_SIZE = 2048;
	localparam int SLOT_BITS  = $clog2(TABLE_SIZE);

	typedef enum logic [2:0] {
		REQ_LOOKUP = 3'd0,
		REQ_GET    = 3'd1,
		REQ_WRITE  = 3'd2,
		REQ_DELETE = 3'd3,
		REQ_RANGE  = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_INSERTED = 3'd1,
		ST_MISS     = 3'd2,
		ST_FULL     = 3'd3,
		ST_IGNORED  = 3'd4,
		ST_DELETED  = 3'd5
	} status_t;

endpackage

@@ rtl/lpht_ram.sv @@
// ----------------------------------------------------------------------------
// lpht_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ rtl/linear_probe_hash_table_unit.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open-addressing key/payload map with linear probing and backward-shift
// deletion, held in two single-port RAMs.
// ----------------------------------------------------------------------------
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall | req_type key range_size write_value
// out     | output    | out_valid/out_stall | status slot_index read_value
//
// Each slot visit is an address state, then a check of registered read data.
// A lookup or insert passes HASH, then PROBE_RD and PROBE_CHK per probe, then
// DONE; a null or unknown request goes from IDLE to DONE. A delete runs the
// repair loop: REP_RD, REP_HASH and REP_CHK per slot walked, REP_CLR per
// shifted entry, REP_RD and REP_HASH for the empty slot that ends it. A range
// delete visits every slot through RNG_RD and RNG_CHK, plus the repair after
// every removed key. After reset a clearing pass writes every slot, with
// in_stall high. A result is held in an output register while out_stall is
// high; the next transaction is accepted once that register is free.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit
	import lpht_pkg::*;
#(
	parameter int PAYLOAD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [31:0] key,
	input  logic [31:0] range_size,
	input  logic [31:0] write_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [10:0] slot_index,
	output logic [31:0] read_value
);

	localparam int AW = SLOT_BITS;
	localparam int PW = PAYLOAD_BITS;
	localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

	typedef enum logic [3:0] {
		CLEAR, IDLE, HASH, PROBE_RD, PROBE_CHK, REP_RD, REP_HASH, REP_CHK,
		REP_CLR, RNG_RD, RNG_CHK, DONE
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_q, idx_q, hole_q, cur_q, n_q;
	logic              rng_q;
	logic [2:0]        req_q;
	logic [31:0]       key_q, end_q, mul_q, cur_key_q;
	logic [PW-1:0]     wval_q, cur_pl_q;
	logic              we;
	logic [AW-1:0]     addr;
	logic [31:0]       kw, kr;
	logic [PW-1:0]     pw_d, pr;

	function automatic logic [AW-1:0] ring(input logic [AW-1:0] a, input logic [AW-1:0] b);
		return b - a;
	endfunction

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
		return i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] modt(input logic [31:0] h);
		return h[AW-1:0];
	endfunction

	lpht_ram #(.WIDTH(32), .DEPTH(TABLE_SIZE)) u_key (
		.clk(clk), .we(we), .addr(addr), .wdata(kw), .rdata(kr));
	lpht_ram #(.WIDTH(PW), .DEPTH(TABLE_SIZE)) u_pl (
		.clk(clk), .we(we), .addr(addr), .wdata(pw_d), .rdata(pr));

	logic hit, emp, in_rng, need_mov;
	logic [AW-1:0] home_cur;
	assign hit  = kr == key_q;
	assign emp  = kr == 32'd0;
	assign in_rng = kr != 32'd0 && kr >= key_q && kr < end_q;
	assign home_cur = modt(mul_q);
	assign need_mov = ring(home_cur, cur_q) > ring(home_cur, hole_q);

	always_comb begin
		we   = 1'b0;
		addr = idx_q;
		kw   = '0;
		pw_d = '0;
		unique case (state_q)
			CLEAR: begin
				we = 1'b1; addr = clr_q;
			end
			PROBE_CHK: begin
				if ((req_q == REQ_GET || req_q == REQ_WRITE) && (hit || emp)) begin
					we = 1'b1; kw = key_q;
					pw_d = (req_q == REQ_WRITE) ? wval_q : (hit ? pr : '0);
				end else if (req_q == REQ_DELETE && hit) begin
					we = 1'b1;
				end
			end
			REP_RD: addr = cur_q;
			REP_CHK: begin
				if (need_mov) begin
					we = 1'b1; addr = hole_q; kw = cur_key_q; pw_d = cur_pl_q;
				end
			end
			REP_CLR: begin
				we = 1'b1; addr = hole_q;
			end
			REP_HASH: addr = cur_q;
			RNG_RD: addr = idx_q;
			RNG_CHK: begin
				if (in_rng) we = 1'b1;
			end
			default: ;
		endcase
	end

	assign in_stall = state_q != IDLE || out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
			clr_q <= '0;
			idx_q <= '0;
			hole_q <= '0;
			cur_q <= '0;
			n_q <= '0;
			rng_q <= 1'b0;
			req_q <= '0;
			key_q <= '0;
			end_q <= '0;
			mul_q <= '0;
			cur_key_q <= '0;
			wval_q <= '0;
			cur_pl_q <= '0;
			out_valid <= 1'b0;
			status <= ST_IGNORED;
			slot_index <= '0;
			read_value <= '0;
		end else begin
			if (state_q == DONE) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			unique case (state_q)
				CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST) state_q <= IDLE;
				end
				IDLE: if (in_valid && !in_stall) begin
					req_q <= req_type; key_q <= key;
					end_q <= key + range_size;
					wval_q <= PW'(write_value);
					status <= ST_IGNORED; slot_index <= '0; read_value <= '0;
					mul_q <= 32'({2'b00, key[31:2]} * GOLDEN_MULT);
					rng_q <= 1'b0;
					if (req_type <= REQ_DELETE && key != 32'd0) state_q <= HASH;
					else if (req_type == REQ_RANGE && key != 32'd0 &&
							range_size != 32'd0) begin
						status <= ST_DELETED; idx_q <= '0; rng_q <= 1'b1;
						state_q <= RNG_RD;
					end else state_q <= DONE;
				end
				HASH: begin
					idx_q <= modt(mul_q); n_q <= '0; state_q <= PROBE_RD;
				end
				PROBE_RD: state_q <= PROBE_CHK;
				PROBE_CHK: begin
					if (hit || emp) begin
						state_q <= DONE;
						unique case (req_q)
							REQ_LOOKUP: if (hit) begin
								status <= ST_HIT; slot_index <= idx_q;
								read_value <= 32'(pr);
							end else status <= ST_MISS;
							REQ_GET, REQ_WRITE: begin
								status <= hit ? ST_HIT : ST_INSERTED;
								slot_index <= idx_q;
								read_value <= 32'((req_q == REQ_WRITE) ? wval_q :
									(hit ? pr : '0));
							end
							default: if (hit) begin
								status <= ST_DELETED; hole_q <= idx_q;
								cur_q <= nxt(idx_q); state_q <= REP_RD;
							end else status <= ST_MISS;
						endcase
					end else if (n_q == LAST) begin
						status <= (req_q == REQ_GET || req_q == REQ_WRITE) ? ST_FULL : ST_MISS;
						state_q <= DONE;
					end else begin
						n_q <= n_q + AW'(1); idx_q <= nxt(idx_q); state_q <= PROBE_RD;
					end
				end
				REP_RD: state_q <= REP_HASH;
				REP_HASH: begin
					if (kr == 32'd0) begin
						if (rng_q) state_q <= RNG_RD;
						else state_q <= DONE;
					end else begin
						cur_key_q <= kr; cur_pl_q <= pr;
						mul_q <= 32'({2'b00, kr[31:2]} * GOLDEN_MULT);
						state_q <= REP_CHK;
					end
				end
				REP_CHK: begin
					if (need_mov) begin
						hole_q <= cur_q;
						state_q <= REP_CLR;
					end else begin
						cur_q <= nxt(cur_q);
						state_q <= REP_RD;
					end
				end
				REP_CLR: begin
					cur_q <= nxt(cur_q);
					state_q <= REP_RD;
				end
				RNG_RD: state_q <= RNG_CHK;
				RNG_CHK: begin
					if (in_rng) begin
						hole_q <= idx_q; cur_q <= nxt(idx_q); state_q <= REP_RD;
					end else if (idx_q == LAST) state_q <= DONE;
					else begin
						idx_q <= idx_q + AW'(1); state_q <= RNG_RD;
					end
				end
				DONE: state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == CLEAR |-> in_stall)
		else $error("accept during clear");
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("accept with pending result");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == IDLE)
		else $error("result while busy");

endmodule

@@ tb/linear_probe_hash_table_unit_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit_checker
// Watches both channels of the hash table unit and keeps its own copy of the
// slot store. Each accepted request is applied to that copy to predict its
// status, slot and payload. Each accepted response is compared field by field
// with the oldest prediction, and every mismatch is counted.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit_checker
	import lpht_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [31:0] key,
	input  logic [31:0] range_size,
	input  logic [31:0] write_value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [10:0] slot_index,
	input  logic [31:0] read_value,
	output int          fail_count,
	output int          pending_count
);

	typedef struct packed {
		status_t     st;
		logic [10:0] idx;
		logic [31:0] val;
	} response_t;

	logic [31:0] key_mem [TABLE_SIZE] = '{default: '0};
	logic [31:0] payload_mem [TABLE_SIZE] = '{default: '0};
	response_t   response_q [$];
	int          mismatches = 0;

	assign pending_count = response_q.size();
	assign fail_count = mismatches;

	function automatic int home_of(logic [31:0] k);
		logic [31:0] h;
		h = (k >> 2) * GOLDEN_MULT;
		return int'(h % TABLE_SIZE);
	endfunction

	function automatic int ring_gap(int from, int to);
		return (to + TABLE_SIZE - from) % TABLE_SIZE;
	endfunction

	// found: slot holds k; else where is the empty slot ending the chain, or -1
	function automatic bit find_slot(logic [31:0] k, output int where);
		int i;
		i = home_of(k);
		where = -1;
		for (int n = 0; n < TABLE_SIZE; n++) begin
			if (key_mem[i] == k) begin
				where = i;
				return 1'b1;
			end
			if (key_mem[i] == 0) begin
				where = i;
				return 1'b0;
			end
			i = (i + 1) % TABLE_SIZE;
		end
		return 1'b0;
	endfunction

	task automatic shift_out(int hole);
		int cur;
		int ideal;
		key_mem[hole] = '0;
		payload_mem[hole] = '0;
		cur = (hole + 1) % TABLE_SIZE;
		while (key_mem[cur] != 0) begin
			ideal = home_of(key_mem[cur]);
			if (ring_gap(ideal, cur) > ring_gap(ideal, hole)) begin
				key_mem[hole] = key_mem[cur];
				payload_mem[hole] = payload_mem[cur];
				hole = cur;
				key_mem[hole] = '0;
				payload_mem[hole] = '0;
			end
			cur = (cur + 1) % TABLE_SIZE;
		end
	endtask

	task automatic apply_request(logic [2:0] rq, logic [31:0] k, logic [31:0] sz,
			logic [31:0] wv);
		response_t r;
		int where;
		bit hit;
		logic [31:0] stop;
		int i;
		r = '{st: ST_IGNORED, idx: '0, val: '0};
		if (rq <= REQ_DELETE && k == 0) begin
			r.st = ST_IGNORED;
		end else if (rq == REQ_LOOKUP) begin
			if (find_slot(k, where)) begin
				r = '{st: ST_HIT, idx: where[10:0], val: payload_mem[where]};
			end else begin
				r.st = ST_MISS;
			end
		end else if (rq == REQ_GET || rq == REQ_WRITE) begin
			hit = find_slot(k, where);
			if (hit) begin
				r.st = ST_HIT;
			end else if (where >= 0) begin
				r.st = ST_INSERTED;
				key_mem[where] = k;
				payload_mem[where] = '0;
			end else begin
				r.st = ST_FULL;
			end
			if (r.st != ST_FULL) begin
				if (rq == REQ_WRITE)
					payload_mem[where] = wv;
				r.idx = where[10:0];
				r.val = payload_mem[where];
			end
		end else if (rq == REQ_DELETE) begin
			if (find_slot(k, where)) begin
				shift_out(where);
				r.st = ST_DELETED;
			end else begin
				r.st = ST_MISS;
			end
		end else if (rq == REQ_RANGE) begin
			if (k != 0 && sz != 0) begin
				stop = k + sz;
				i = 0;
				while (i < TABLE_SIZE) begin
					if (key_mem[i] != 0 && key_mem[i] >= k && key_mem[i] < stop)
						shift_out(i);
					else
						i++;
				end
				r.st = ST_DELETED;
			end
		end
		response_q.push_back(r);
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		response_t e;
		if (arst_n) begin
			if (in_valid && !in_stall)
				apply_request(req_type, key, range_size, write_value);
			if (out_valid && !out_stall) begin
				if (response_q.size() == 0) begin
					report("unexpected transaction", {29'd0, status}, '0);
				end else begin
					e = response_q.pop_front();
					if (status !== e.st)
						report("status", {29'd0, status}, {29'd0, e.st});
					if (slot_index !== e.idx)
						report("slot_index", {21'd0, slot_index}, {21'd0, e.idx});
					if (read_value !== e.val)
						report("read_value", read_value, e.val);
				end
			end
		end
	end

endmodule

@@ tb/linear_probe_hash_table_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit_tb
// Drives directed and random requests into the hash table unit with random
// gaps and output stalls. Keys come from a small pool so that probe chains,
// collisions and shifts all occur; the checker predicts and compares every
// response.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit_tb;
	import lpht_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  req_type = '0;
	logic [31:0] key = '0;
	logic [31:0] range_size = '0;
	logic [31:0] write_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [10:0] slot_index;
	logic [31:0] read_value;
	int          fail_count;
	int          pending_count;
	int          out_wait = 0;
	bit          sending_done = 1'b0;
	logic [31:0] key_pool [64];

	always #1 clk = ~clk;

	linear_probe_hash_table_unit dut (.*);

	linear_probe_hash_table_unit_checker checker_i (.*);

	task automatic send(logic [2:0] rq, logic [31:0] k, logic [31:0] sz,
			logic [31:0] wv);
		int gap;
		gap = $urandom_range(0, 11);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		key <= k;
		range_size <= sz;
		write_value <= wv;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_key();
		return key_pool[$urandom_range(0, 63)];
	endfunction

	// hold each result for a drawn number of cycles
	always @(posedge clk) begin
		int w;
		if (out_valid && !out_stall) begin
			w = $urandom_range(0, 11);
			out_wait <= w;
			out_stall <= (w != 0);
		end else if (out_valid && out_wait != 0) begin
			out_wait <= out_wait - 1;
			out_stall <= (out_wait > 1);
		end
	end

	initial begin
		logic [31:0] k;
		int op;
		for (int i = 0; i < 64; i++)
			key_pool[i] = $urandom | 32'h4;
		// colliding keys with the same home slot, plus the all-ones key
		key_pool[0] = 32'h4;
		key_pool[1] = 32'h4 + (TABLE_SIZE << 2) * 32'd0 + 32'h1;
		key_pool[2] = 32'h5;
		key_pool[3] = 32'h6;
		key_pool[4] = 32'hFFFF_FFFF;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(REQ_LOOKUP, 32'h0, '0, '0);
		send(REQ_GET, 32'h0, '0, '0);
		send(REQ_WRITE, 32'h0, '0, 32'hFFFF_FFFF);
		send(REQ_DELETE, 32'h0, '0, '0);
		send(REQ_LOOKUP, 32'h1234, '0, '0);
		send(REQ_DELETE, 32'h1234, '0, '0);
		send(REQ_GET, 32'h4, '0, '0);
		send(REQ_WRITE, 32'h5, '0, 32'hFFFF_FFFF);
		send(REQ_WRITE, 32'h6, '0, 32'hA5A5_5A5A);
		send(REQ_WRITE, 32'h7, '0, 32'h0);
		send(REQ_GET, 32'h5, '0, '0);
		send(REQ_LOOKUP, 32'h6, '0, '0);
		send(REQ_DELETE, 32'h4, '0, '0);
		send(REQ_LOOKUP, 32'h7, '0, '0);
		send(REQ_WRITE, 32'hFFFF_FFFF, '0, 32'h1);
		send(REQ_RANGE, 32'h0, 32'h10, '0);
		send(REQ_RANGE, 32'h5, 32'h0, '0);
		send(REQ_RANGE, 32'hFFFF_FFF0, 32'h20, '0);
		send(REQ_RANGE, 32'h5, 32'h2, '0);
		send(3'd5, 32'h6, '0, '0);
		send(3'd7, 32'h6, '0, '0);
		send(REQ_RANGE, 32'h1, 32'hFFFF_FFFE, '0);
		drain();

		for (int n = 0; n < 1420; n++) begin
			k = pick_key();
			if ($urandom_range(0, 19) == 0)
				k = $urandom;
			op = $urandom_range(0, 99);
			if (op < 20)
				send(REQ_LOOKUP, k, $urandom, $urandom);
			else if (op < 40)
				send(REQ_GET, k, $urandom, $urandom);
			else if (op < 70)
				send(REQ_WRITE, k, $urandom, $urandom);
			else if (op < 88)
				send(REQ_DELETE, k, $urandom, $urandom);
			else if (op < 93)
				send(REQ_RANGE, k, $urandom_range(1, 32'h2000_0000), $urandom);
			else if (op < 96)
				send(3'($urandom_range(5, 7)), k, $urandom, $urandom);
			else
				send(3'($urandom_range(0, 3)), 32'h0, $urandom, $urandom);
			if (n == 700)
				drain();
		end

		// write a key, then a range delete whose end wraps to zero and removes nothing
		send(REQ_WRITE, 32'h0FFF_FFF0, '0, 32'h5);
		send(REQ_GET, 32'h0FFF_FFF0, '0, '0);
		send(REQ_LOOKUP, 32'h0FFF_FFF4, '0, '0);
		send(REQ_RANGE, 32'h1, 32'hFFFF_FFFF, '0);
		send(REQ_GET, 32'h0FFF_FFF0, '0, '0);
		drain();
		sending_done = 1'b1;
	end

	initial begin
		wait (sending_done);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#8000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

@@ linear_probe_hash_table_unit.f @@
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/linear_probe_hash_table_unit.sv
tb/linear_probe_hash_table_unit_checker.sv
tb/linear_probe_hash_table_unit_tb.sv
